@@ sv/stwa_pkg.sv @@
// shared types and codes for the session table with aging
// no dependencies
`default_nettype none
package stwa_pkg;
  localparam int KEY_W = 50;
  localparam int AGE_W = 32;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_QUERY  = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_SWEEP  = 3'd4;

  localparam logic [3:0] ST_CREATED   = 4'd0;
  localparam logic [3:0] ST_REFRESHED = 4'd1;
  localparam logic [3:0] ST_BLACKLIST = 4'd2;
  localparam logic [3:0] ST_FULL      = 4'd3;
  localparam logic [3:0] ST_PRESENT   = 4'd4;
  localparam logic [3:0] ST_ABSENT    = 4'd5;
  localparam logic [3:0] ST_REMOVED   = 4'd6;
  localparam logic [3:0] ST_TICKED    = 4'd7;
  localparam logic [3:0] ST_EXPIRED   = 4'd8;
  localparam logic [3:0] ST_NONE_EXP  = 4'd9;

  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_BL_COUNT = 3'd1;
  localparam logic [2:0] REG_BL_FIRST = 3'd2;

  typedef struct packed {
    logic [2:0]       action;
    logic [KEY_W-1:0] imsi;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [KEY_W-1:0] imsi_out;
    logic [AGE_W-1:0] age_seconds;
    logic             last;
  } out_word_t;

  // classified command from front to back
  typedef struct packed {
    logic [2:0]       action;
    logic             blocked;
    logic [KEY_W-1:0] imsi;
  } cmd_t;
endpackage
`default_nettype wire

@@ sv/stwa_ram.sv @@
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module stwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/stwa_front.sv @@
// front end: accepts words, drops unknown actions, checks the blacklist, queues commands
// depends on stwa_pkg
`default_nettype none
module stwa_front #(
  parameter int BLACKLIST_SIZE = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire stwa_pkg::in_word_t  in_word,
  input  wire logic [2:0]          bl_count,
  input  wire logic [BLACKLIST_SIZE-1:0][stwa_pkg::KEY_W-1:0] bl_regs,
  output logic                     cmd_valid,
  input  wire logic                cmd_take,
  output stwa_pkg::cmd_t           cmd
);
  import stwa_pkg::*;
  // two-entry queue
  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       blocked;
  logic [2:0] lim;
  logic       push_ok;

  always_comb begin
    lim = (bl_count > 3'(BLACKLIST_SIZE)) ? 3'(BLACKLIST_SIZE) : bl_count;
    blocked = 1'b0;
    for (int i = 0; i < BLACKLIST_SIZE; i++)
      if (3'(i) < lim && bl_regs[i] == in_word.imsi) blocked = 1'b1;
  end

  assign in_full   = cnt_r == 2'd2;
  assign push_ok   = in_push && !in_full && in_word.action <= ACT_SWEEP;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(cmd_take && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_r <= ~wr_r;
      if (cmd_take && cmd_valid) rd_r <= ~rd_r;
    end
    if (push_ok) q_r[wr_r] <= '{action: in_word.action, blocked: blocked,
                                imsi: in_word.imsi};
  end
endmodule
`default_nettype wire

@@ sv/stwa_back.sv @@
// back end: scans the table one slot a cycle, pausing on expired words; emits results
// depends on stwa_pkg and stwa_ram
`default_nettype none
module stwa_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire stwa_pkg::cmd_t     cmd,
  input  wire logic [15:0]        timeout,
  output logic                    out_valid,
  input  wire logic               out_take,
  output stwa_pkg::out_word_t     out_word
);
  import stwa_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0] LAST_IDX = (AW+1)'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_r;
  cmd_t                   cmd_r;
  logic [AW:0]            idx_r;      // next slot to read, on the ram read address
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [AGE_W-1:0]       now_r;
  logic                   hit_r, free_r, any_r;
  logic [AW-1:0]          hit_idx_r, free_idx_r;
  logic                   rd_ok_r;
  logic [AW-1:0]          rd_idx_r;
  out_word_t              res_r;
  logic                   res_v_r;

  logic [KEY_W-1:0] key_q;
  logic [AGE_W-1:0] stamp_q;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wkey;
  logic             kwe;
  logic [AGE_W-1:0] age;
  logic             expire_hit;

  stwa_ram #(.WIDTH(KEY_W), .DEPTH(2**AW)) u_key (
    .clk, .we(kwe), .waddr, .wdata(wkey), .raddr(idx_r[AW-1:0]), .rdata(key_q));
  stwa_ram #(.WIDTH(AGE_W), .DEPTH(2**AW)) u_stamp (
    .clk, .we, .waddr, .wdata(now_r), .raddr(idx_r[AW-1:0]), .rdata(stamp_q));

  assign age       = now_r - stamp_q;
  assign out_valid = res_v_r;
  assign out_word  = res_r;
  assign cmd_take  = state_r == S_IDLE && cmd_valid && !res_v_r;
  assign expire_hit = state_r == S_SCAN && rd_ok_r && cmd_r.action == ACT_SWEEP &&
                      valid_r[rd_idx_r] && age >= AGE_W'(timeout);

  // ram writes happen in eval state only
  always_comb begin
    we = 1'b0; kwe = 1'b0; waddr = hit_idx_r; wkey = cmd_r.imsi;
    if (state_r == S_EVAL && cmd_r.action == ACT_CREATE && !cmd_r.blocked) begin
      if (hit_r) we = 1'b1;
      else if (free_r) begin
        we = 1'b1; kwe = 1'b1; waddr = free_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; now_r <= '0; res_v_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      if (out_take && res_v_r) res_v_r <= 1'b0;
      rd_ok_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_take) begin
            cmd_r <= cmd; idx_r <= '0; hit_r <= 1'b0; free_r <= 1'b0;
            any_r <= 1'b0;
            if (cmd.action == ACT_TICK) begin
              now_r <= now_r + AGE_W'(1);
              res_r <= '{ST_TICKED, '0, '0, 1'b1}; res_v_r <= 1'b1;
            end else if (cmd.action == ACT_CREATE && cmd.blocked) begin
              res_r <= '{ST_BLACKLIST, cmd.imsi, '0, 1'b1}; res_v_r <= 1'b1;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // previous read's data is on the ram outputs
          if (rd_ok_r) begin
            if (cmd_r.action == ACT_SWEEP) begin
              if (expire_hit) begin
                valid_r[rd_idx_r] <= 1'b0;
                res_r <= '{ST_EXPIRED, key_q, age, 1'b0}; res_v_r <= 1'b1;
                any_r <= 1'b1;
                state_r <= S_OUT;
              end
            end else if (valid_r[rd_idx_r] && key_q == cmd_r.imsi && !hit_r) begin
              hit_r <= 1'b1; hit_idx_r <= rd_idx_r;
            end
          end
          if (!free_r && idx_r <= LAST_IDX && !valid_r[idx_r[AW-1:0]]) begin
            free_r <= 1'b1; free_idx_r <= idx_r[AW-1:0];
          end
          // an expired word pauses the scan before the next read goes out
          if (idx_r <= LAST_IDX && !expire_hit) begin
            rd_ok_r <= 1'b1; rd_idx_r <= idx_r[AW-1:0]; idx_r <= idx_r + (AW+1)'(1);
          end
          if (idx_r > LAST_IDX && !rd_ok_r) state_r <= S_EVAL;
        end
        S_OUT: begin
          // hold scan until expired word taken; then resume the scan, or go to eval once all slots are read
          if (!res_v_r || out_take) begin
            if (idx_r > LAST_IDX) state_r <= S_EVAL;
            else state_r <= S_SCAN;
          end
        end
        S_EVAL: begin
          if (!res_v_r || out_take) begin
            res_v_r <= 1'b1; state_r <= S_IDLE;
            case (cmd_r.action)
              ACT_CREATE: begin
                if (hit_r) res_r <= '{ST_REFRESHED, cmd_r.imsi, '0, 1'b1};
                else if (free_r) begin
                  res_r <= '{ST_CREATED, cmd_r.imsi, '0, 1'b1};
                  valid_r[free_idx_r] <= 1'b1;
                end else res_r <= '{ST_FULL, cmd_r.imsi, '0, 1'b1};
              end
              ACT_QUERY:
                res_r <= '{hit_r ? ST_PRESENT : ST_ABSENT, cmd_r.imsi, '0, 1'b1};
              ACT_REMOVE: begin
                res_r <= '{ST_REMOVED, cmd_r.imsi, '0, 1'b1};
                if (hit_r) valid_r[hit_idx_r] <= 1'b0;
              end
              default: begin
                if (any_r) begin
                  // marker word closes the sweep; it only sets last on the held word
                  res_r <= '{ST_EXPIRED, '0, '0, 1'b1};
                end else res_r <= '{ST_NONE_EXP, '0, '0, 1'b1};
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/session_table_with_aging_unit.sv @@
// session table with aging: front classifier, command queue, table scanner
// depends on stwa_pkg, stwa_front, stwa_back
// tick and blacklisted create skip the scan; lookups and sweeps scan the table
//   ram one slot a cycle, and only one command is processed at a time
// sweeps stall on each expired word until the output stage takes it
// reset: synchronous active low, all entries invalid, clock at zero
`default_nettype none
module session_table_with_aging_unit #(
  parameter int TABLE_DEPTH    = 64,
  parameter int BLACKLIST_SIZE = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire stwa_pkg::in_word_t   in_data,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output stwa_pkg::out_word_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [stwa_pkg::KEY_W-1:0] cfg_data
);
  import stwa_pkg::*;
  logic [15:0] timeout_r;
  logic [2:0]  bl_count_r;
  logic [BLACKLIST_SIZE-1:0][KEY_W-1:0] bl_r;
  logic        cmd_valid, cmd_take, ov;
  cmd_t        cmd;
  out_word_t   ow;
  out_word_t   pend_r;
  logic        hold_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd30; bl_count_r <= '0; bl_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEOUT) timeout_r <= cfg_data[15:0];
      else if (cfg_index == REG_BL_COUNT) bl_count_r <= cfg_data[2:0];
      else
        for (int i = 0; i < BLACKLIST_SIZE; i++)
          if (cfg_index == REG_BL_FIRST + 3'(i)) bl_r[i] <= cfg_data;
    end
  end

  stwa_front #(.BLACKLIST_SIZE(BLACKLIST_SIZE)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word(in_data),
    .bl_count(bl_count_r), .bl_regs(bl_r), .cmd_valid, .cmd_take, .cmd);

  // one-word delay holds the latest expired word so last can be set
  logic take_b;
  stwa_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd, .timeout(timeout_r),
    .out_valid(ov), .out_take(take_b), .out_word(ow));

  // the sweep-close marker (expired with last, zero key) finalizes the held word
  logic marker;
  assign marker = ow.status == ST_EXPIRED && ow.last;
  logic pend_v_r;
  assign out_empty = !(pend_v_r && (!hold_r));
  assign out_data  = pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0; hold_r <= 1'b0;
    end else begin
      if (!out_empty && out_pop) pend_v_r <= 1'b0;
      if (ov && take_b) begin
        if (marker) begin
          pend_r.last <= 1'b1; hold_r <= 1'b0;
        end else begin
          pend_r <= ow; pend_v_r <= 1'b1;
          hold_r <= ow.status == ST_EXPIRED;
        end
      end else if (ov && !marker && hold_r) begin
        // another expired word follows, so the held one is not final
        hold_r <= 1'b0;
      end
    end
  end
  // expired words wait until the next word proves whether they are final
  assign take_b = ov && (marker ? (pend_v_r && hold_r)
                                : (!pend_v_r || (!out_empty && out_pop)));
endmodule
`default_nettype wire

@@ sv/stwa_checker.sv @@
// port-level checks for the session table unit
// depends on stwa_pkg; bound to session_table_with_aging_unit
`default_nettype none
module stwa_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_full,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire stwa_pkg::out_word_t out_data
);
  import stwa_pkg::*;
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_full && out_empty) else $error("not idle after reset");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.status <= ST_NONE_EXP) else $error("bad status");
  a_age: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != ST_EXPIRED |-> out_data.age_seconds == '0)
    else $error("age on non-expired word");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != ST_EXPIRED |-> out_data.last)
    else $error("single word without last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("word changed while waiting");
endmodule

bind session_table_with_aging_unit stwa_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data);
`default_nettype wire

@@ verif/testbench.sv @@
// testbench for session_table_with_aging_unit: drives random and directed
// words, predicts results with a behavioral table model, checks in order
// depends on stwa_pkg and session_table_with_aging_unit
module testbench;
  import stwa_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [KEY_W-1:0] cfg_data = '0;

  session_table_with_aging_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted table state
  logic [15:0] tmo;
  logic [2:0] bl_cnt;
  logic [KEY_W-1:0] bl_key [4];
  logic slot_valid [DEPTH];
  logic [KEY_W-1:0] slot_key [DEPTH];
  logic [AGE_W-1:0] slot_stamp [DEPTH];
  logic [AGE_W-1:0] clock_secs;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int pop_gap = 0;
  bit fast_phase = 1'b0;
  logic [KEY_W-1:0] key_pool [16];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void push_exp(logic [3:0] st, logic [KEY_W-1:0] k,
                                   logic [AGE_W-1:0] age, logic lst);
    out_word_t w;
    w.status = st; w.imsi_out = k; w.age_seconds = age; w.last = lst;
    expected_words = {expected_words, w};
  endfunction

  function automatic void predict_session(in_word_t w);
    int hit, n, lim;
    logic blocked;
    logic [AGE_W-1:0] age;
    hit = -1;
    n = 0;
    blocked = 1'b0;
    lim = (bl_cnt > 4) ? 4 : bl_cnt;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == w.imsi) hit = i;
    case (w.action)
      ACT_CREATE: begin
        for (int i = 0; i < lim; i++) if (bl_key[i] == w.imsi) blocked = 1'b1;
        if (blocked) begin
          push_exp(ST_BLACKLIST, w.imsi, '0, 1'b1);
        end else if (hit >= 0) begin
          slot_stamp[hit] = clock_secs;
          push_exp(ST_REFRESHED, w.imsi, '0, 1'b1);
        end else begin
          for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && !slot_valid[i]) begin
              hit = i;
              slot_valid[i] = 1'b1;
              slot_key[i] = w.imsi;
              slot_stamp[i] = clock_secs;
            end
          push_exp(hit >= 0 ? ST_CREATED : ST_FULL, w.imsi, '0, 1'b1);
        end
      end
      ACT_QUERY: push_exp(hit >= 0 ? ST_PRESENT : ST_ABSENT, w.imsi, '0, 1'b1);
      ACT_REMOVE: begin
        if (hit >= 0) slot_valid[hit] = 1'b0;
        push_exp(ST_REMOVED, w.imsi, '0, 1'b1);
      end
      ACT_TICK: begin
        clock_secs = clock_secs + 1;
        push_exp(ST_TICKED, '0, '0, 1'b1);
      end
      ACT_SWEEP: begin
        for (int i = 0; i < DEPTH; i++) begin
          age = clock_secs - slot_stamp[i];
          if (slot_valid[i] && age >= {16'd0, tmo}) begin
            slot_valid[i] = 1'b0;
            push_exp(ST_EXPIRED, slot_key[i], age, 1'b0);
            n++;
          end
        end
        if (n == 0) push_exp(ST_NONE_EXP, '0, '0, 1'b1);
        else expected_words[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if (fast_phase) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_session(in_data);
        void'(pending_words.pop_front());
      end
      if (in_push && in_full) begin
        // hold the word
      end else if (send_gap > 0) begin
        in_push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
        in_push <= 1'b1;
        in_data <= pending_words[0];
        send_gap <= pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (cfg_valid && cfg_ready) || (out_pop && !out_empty))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word status %0d", out_data.status));
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data.status !== e.status)
            report($sformatf("status %0d want %0d", out_data.status, e.status));
          if (out_data.imsi_out !== e.imsi_out)
            report($sformatf("imsi %0d want %0d", out_data.imsi_out, e.imsi_out));
          if (out_data.age_seconds !== e.age_seconds)
            report($sformatf("age %0d want %0d", out_data.age_seconds,
                             e.age_seconds));
          if (out_data.last !== e.last)
            report($sformatf("last %0b want %0b", out_data.last, e.last));
        end
      end
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        out_pop <= 1'b1;
        pop_gap <= pick_gap();
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL session_table_with_aging_unit");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [KEY_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMEOUT: tmo = val[15:0];
      REG_BL_COUNT: bl_cnt = val[2:0];
      default: if (idx >= REG_BL_FIRST && idx < REG_BL_FIRST + 4)
        bl_key[idx - REG_BL_FIRST] = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_push || expected_words.size() != 0)
      @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
  endtask

  task automatic add_word(input logic [2:0] act, input logic [KEY_W-1:0] k);
    in_word_t w;
    w.action = act;
    w.imsi = k;
    pending_words = {pending_words, w};
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom, $urandom});
  endfunction

  // mostly well-formed session traffic from a small key pool
  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) add_word(ACT_CREATE, key_pool[$urandom_range(0, 15)]);
      else if (r < 47) add_word(ACT_QUERY, key_pool[$urandom_range(0, 15)]);
      else if (r < 57) add_word(ACT_REMOVE, key_pool[$urandom_range(0, 15)]);
      else if (r < 82) add_word(ACT_TICK, rand_key());
      else if (r < 92) add_word(ACT_SWEEP, rand_key());
      else if (r < 97) add_word(3'($urandom_range(0, 2)), rand_key());
      else add_word(3'($urandom_range(5, 7)), rand_key());
    end
    drain();
  endtask

  initial begin
    tmo = 16'd30;
    bl_cnt = '0;
    clock_secs = '0;
    for (int i = 0; i < 4; i++) bl_key[i] = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_stamp[i] = '0;
    end
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = {KEY_W{1'b1}};
    key_pool[2] = 50'd999999999999999;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults, extremes, blacklist, zero timeout, unknown actions
    write_reg(REG_BL_FIRST, key_pool[2]);
    write_reg(3'(REG_BL_FIRST + 1), {KEY_W{1'b1}});
    write_reg(3'(REG_BL_FIRST + 2), key_pool[3]);
    write_reg(3'(REG_BL_FIRST + 3), key_pool[4]);
    add_word(ACT_CREATE, key_pool[2]);
    add_word(ACT_CREATE, '0);
    add_word(ACT_CREATE, {KEY_W{1'b1}});
    add_word(ACT_CREATE, '0);
    add_word(ACT_QUERY, '0);
    add_word(ACT_QUERY, key_pool[5]);
    add_word(ACT_REMOVE, key_pool[5]);
    add_word(3'd5, key_pool[5]);
    add_word(3'd7, '0);
    add_word(ACT_SWEEP, '0);
    add_word(ACT_TICK, {KEY_W{1'b1}});
    drain();
    write_reg(REG_BL_COUNT, KEY_W'(7));
    add_word(ACT_CREATE, key_pool[2]);
    add_word(ACT_CREATE, {KEY_W{1'b1}});
    add_word(ACT_CREATE, key_pool[4]);
    drain();
    write_reg(REG_BL_COUNT, KEY_W'(2));
    write_reg(REG_TIMEOUT, KEY_W'(0));
    add_word(ACT_CREATE, key_pool[4]);
    add_word(ACT_SWEEP, '0);
    add_word(ACT_SWEEP, '0);
    drain();
    // fill the table past capacity with no send or pop gaps, then expire all
    fast_phase = 1'b1;
    write_reg(REG_TIMEOUT, KEY_W'(65535));
    for (int i = 0; i < DEPTH + 2; i++) add_word(ACT_CREATE, rand_key());
    add_word(ACT_SWEEP, '0);
    drain();
    fast_phase = 1'b0;
    write_reg(REG_TIMEOUT, KEY_W'(0));
    add_word(ACT_SWEEP, '0);
    drain();

    write_reg(REG_TIMEOUT, KEY_W'(3));
    write_reg(REG_BL_COUNT, KEY_W'(4));
    write_reg(REG_BL_FIRST, key_pool[6]);
    random_phase(145);
    write_reg(REG_TIMEOUT, KEY_W'(1));
    write_reg(REG_BL_COUNT, KEY_W'(1));
    random_phase(100);
    write_reg(REG_TIMEOUT, KEY_W'(6));
    write_reg(REG_BL_COUNT, KEY_W'(0));
    random_phase(100);

    if (errors == 0) begin
      $display("PASS session_table_with_aging_unit");
    end else begin
      $display("FAIL session_table_with_aging_unit");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/stwa_pkg.sv
sv/stwa_ram.sv
sv/stwa_front.sv
sv/stwa_back.sv
sv/session_table_with_aging_unit.sv
sv/stwa_checker.sv
verif/testbench.sv
